### rtl/core/pgc_pkg.sv
// ----------------------------------------------------------------------------
// pgc_pkg
// shared widths, codes and transaction types of the palette gradient color map
// ----------------------------------------------------------------------------
package pgc_pkg;

  // field widths
  localparam int ESC_W      = 24;
  localparam int IDX_W      = 4;
  localparam int COLOR_W    = 32;
  localparam int SIZE_W     = 5;
  localparam int START_W    = 4;
  localparam int RANGE_W    = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // color word layout: blended channels in the low bytes, top byte copied
  localparam int CH_W   = 8;
  localparam int NUM_CH = 3;

  // operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_COLOR = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_RANGE  = 2'd2;

  // configuration reset values
  localparam logic [SIZE_W-1:0]  SIZE_RESET  = 5'd16;
  localparam logic [START_W-1:0] START_RESET = 4'd0;
  localparam logic [RANGE_W-1:0] RANGE_RESET = 24'd256;

  // transaction fields that ride along the arithmetic pipeline
  typedef struct packed {
    logic               operation;
    logic [IDX_W-1:0]   entry_index;
    logic [COLOR_W-1:0] entry_color;
  } pgc_item_t;

  // palette write port
  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   idx;
    logic [COLOR_W-1:0] data;
  } pgc_wr_t;

endpackage

### rtl/core/pgc_div_pipe.sv
// ----------------------------------------------------------------------------
// pgc_div_pipe
// restoring divider, one quotient bit per pipeline stage, with sideband
// ----------------------------------------------------------------------------
module pgc_div_pipe import pgc_pkg::*; #(
  parameter int STEPS = 24,
  parameter int DW    = 24,
  parameter int SBW   = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             valid_i,
  input  logic [DW-1:0]    rem_i,     // partial remainder, below divisor
  input  logic [STEPS-1:0] bits_i,    // dividend bits, msb first
  input  logic [DW-1:0]    divisor,
  input  logic [SBW-1:0]   side_i,
  output logic             valid_o,
  output logic [DW-1:0]    rem_o,
  output logic [STEPS-1:0] quo_o,
  output logic [SBW-1:0]   side_o
);

  logic             vld_r  [STEPS];
  logic [DW-1:0]    rem_r  [STEPS];
  logic [STEPS-1:0] bits_r [STEPS];   // remaining dividend bits, quotient shifts in
  logic [SBW-1:0]   side_r [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_stage
    logic             vld_src;
    logic [DW-1:0]    rem_src;
    logic [STEPS-1:0] bits_src;
    logic [SBW-1:0]   side_src;
    logic [DW:0]      trial;
    logic [DW:0]      diff;
    logic             ge;
    logic [DW-1:0]    rem_nxt;
    logic [STEPS-1:0] bits_nxt;

    if (k == 0) begin : g_first
      assign vld_src  = valid_i;
      assign rem_src  = rem_i;
      assign bits_src = bits_i;
      assign side_src = side_i;
    end else begin : g_next
      assign vld_src  = vld_r[k-1];
      assign rem_src  = rem_r[k-1];
      assign bits_src = bits_r[k-1];
      assign side_src = side_r[k-1];
    end

    assign trial    = {rem_src, bits_src[STEPS-1]};
    assign diff     = trial - {1'b0, divisor};
    assign ge       = (trial >= {1'b0, divisor});
    assign rem_nxt  = ge ? diff[DW-1:0] : trial[DW-1:0];
    assign bits_nxt = {bits_src[STEPS-2:0], ge};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_src;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k]  <= rem_nxt;
      bits_r[k] <= bits_nxt;
      side_r[k] <= side_src;
    end
  end

  assign valid_o = vld_r[STEPS-1];
  assign rem_o   = rem_r[STEPS-1];
  assign quo_o   = bits_r[STEPS-1];
  assign side_o  = side_r[STEPS-1];

endmodule

### rtl/core/pgc_palette_mem.sv
// ----------------------------------------------------------------------------
// pgc_palette_mem
// palette store, one write port and two registered read ports
// ----------------------------------------------------------------------------
module pgc_palette_mem import pgc_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  pgc_wr_t                  wr,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [COLOR_W-1:0]       rd_data_a,
  output logic [COLOR_W-1:0]       rd_data_b
);

  localparam int AW = $clog2(DEPTH);

  logic [COLOR_W-1:0] mem [DEPTH];
  logic [COLOR_W-1:0] rd_a_r;
  logic [COLOR_W-1:0] rd_b_r;

  // writes beyond the store are dropped
  always_ff @(posedge clk) begin
    if (wr.en && (32'(wr.idx) < DEPTH)) begin
      mem[AW'(wr.idx)] <= wr.data;
    end
    rd_a_r <= mem[rd_addr_a];
    rd_b_r <= mem[rd_addr_b];
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

### rtl/core/pgc_blend.sv
// ----------------------------------------------------------------------------
// pgc_blend
// linear blend of two palette words per channel, registered output
// ----------------------------------------------------------------------------
module pgc_blend import pgc_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 valid_i,
  input  logic [COLOR_W-1:0]   color_a_i,
  input  logic [COLOR_W-1:0]   color_b_i,
  input  logic [FRAC_BITS-1:0] frac_i,
  output logic                 valid_o,
  output logic [COLOR_W-1:0]   color_o
);

  localparam int SUM_W = CH_W + FRAC_BITS + 2;
  localparam logic [FRAC_BITS:0] FRAC_ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

  logic [FRAC_BITS:0]   wt_a;
  logic [FRAC_BITS:0]   wt_b;
  logic [SUM_W-1:0]     mix [NUM_CH];
  logic [COLOR_W-1:0]   color_nxt;
  logic [COLOR_W-1:0]   color_r;
  logic                 valid_r;

  // c1 * (1 - f) + c2 * f, then drop the fraction
  always_comb begin
    wt_b      = {1'b0, frac_i};
    wt_a      = FRAC_ONE - wt_b;
    color_nxt = '0;
    color_nxt[COLOR_W-1 -: CH_W] = color_a_i[COLOR_W-1 -: CH_W];
    for (int c = 0; c < NUM_CH; c++) begin
      mix[c] = SUM_W'(color_a_i[c*CH_W +: CH_W]) * SUM_W'(wt_a)
             + SUM_W'(color_b_i[c*CH_W +: CH_W]) * SUM_W'(wt_b);
      color_nxt[c*CH_W +: CH_W] = mix[c][FRAC_BITS +: CH_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    color_r <= color_nxt;
  end

  assign valid_o = valid_r;
  assign color_o = color_r;

endmodule

### rtl/core/palette_gradient_color_map_unit.sv
// ----------------------------------------------------------------------------
// palette_gradient_color_map_unit
// cyclic palette gradient: escape value to interpolated pixel color
// ----------------------------------------------------------------------------
// Fully pipelined: a transaction is taken on every clock where start is high
// and busy is low (busy is high only during reset), whether it writes a
// palette entry or colors a value. Each color transaction yields exactly one
// out_valid strobe with out_pixel_color; a write transaction yields nothing.
// Results leave in order and cannot be held off, so the receiver must take
// every strobe. A transaction passes through the 24-stage remainder pipeline
// (escape value mod cycle range), the multiply stage, the quotient pipeline
// that gives the palette position, one bit per stage, and then the index,
// palette read and blend stages. Palette writes travel down the same pipeline
// and land in the palette memory in order with the reads, so a color
// transaction always sees every write taken before it. Palette entries are
// undefined until written; there is no clearing pass after reset.
// Configuration writes are taken on the cfg channel at any time but must only
// be issued while no transaction is in flight.
// ----------------------------------------------------------------------------
module palette_gradient_color_map_unit import pgc_pkg::*; #(
  parameter int PALETTE_DEPTH = 16,
  parameter int FRAC_BITS     = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,

  // input transactions
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_operation,
  input  logic [ESC_W-1:0]      in_escape_value,
  input  logic [IDX_W-1:0]      in_entry_index,
  input  logic [COLOR_W-1:0]    in_entry_color,

  // results
  output logic                  out_valid,
  output logic [COLOR_W-1:0]    out_pixel_color,

  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW  = $clog2(PALETTE_DEPTH);      // palette address
  localparam int SW  = $clog2(PALETTE_DEPTH + 1);  // effective size
  localparam int QW  = AW + FRAC_BITS;             // position: index and fraction
  localparam int PW  = RANGE_W + SW;               // remainder times size
  localparam int SMW = SW + START_W;               // start offset reduction
  localparam int LAT = ESC_W + QW + 4;             // accept to result strobe

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [SIZE_W-1:0]  size_r;
  logic [START_W-1:0] start_r;
  logic [RANGE_W-1:0] range_r;
  logic [SW-1:0]      size_eff;
  logic [RANGE_W-1:0] range_eff;

  assign cfg_ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r  <= SIZE_RESET;
      start_r <= START_RESET;
      range_r <= RANGE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PALETTE_SIZE: size_r  <= cfg_data[SIZE_W-1:0];
        CFG_START_OFFSET: start_r <= cfg_data[START_W-1:0];
        CFG_CYCLE_RANGE:  range_r <= cfg_data[RANGE_W-1:0];
        default: ;
      endcase
    end
  end

  // size zero counts as one, size above the store saturates
  always_comb begin
    priority if (size_r == '0) begin
      size_eff = SW'(1);
    end else if (32'(size_r) > PALETTE_DEPTH) begin
      size_eff = SW'(PALETTE_DEPTH);
    end else begin
      size_eff = SW'(size_r);
    end
  end

  // range zero counts as one
  assign range_eff = (range_r == '0) ? RANGE_W'(1) : range_r;

  // start offset mod size; user must keep config quiet while items are in flight
  logic [SMW-1:0] smod;
  logic [SMW-1:0] smod_step;
  logic [SW-1:0]  start_mod_nxt;
  logic [SW-1:0]  start_mod_r;

  always_comb begin
    smod      = SMW'(start_r);
    smod_step = '0;
    for (int k = START_W - 1; k >= 0; k--) begin
      smod_step = SMW'(size_eff) << k;
      if (smod >= smod_step) begin
        smod = smod - smod_step;
      end
    end
    start_mod_nxt = SW'(smod);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_mod_r <= '0;
    end else begin
      start_mod_r <= start_mod_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // intake
  // --------------------------------------------------------------------------
  pgc_item_t in_item;
  logic      in_accept;

  assign busy      = ~rst_n;
  assign in_accept = start && !busy;

  assign in_item.operation   = in_operation;
  assign in_item.entry_index = in_entry_index;
  assign in_item.entry_color = in_entry_color;

  // --------------------------------------------------------------------------
  // escape value mod cycle range
  // --------------------------------------------------------------------------
  logic               mod_vld;
  logic [RANGE_W-1:0] mod_rem;
  pgc_item_t          mod_item;

  pgc_div_pipe #(
    .STEPS (ESC_W),
    .DW    (RANGE_W),
    .SBW   ($bits(pgc_item_t))
  ) u_mod_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (in_accept),
    .rem_i   ('0),
    .bits_i  (in_escape_value),
    .divisor (range_eff),
    .side_i  (in_item),
    .valid_o (mod_vld),
    .rem_o   (mod_rem),
    .quo_o   (),
    .side_o  (mod_item)
  );

  // --------------------------------------------------------------------------
  // remainder times palette size
  // --------------------------------------------------------------------------
  logic      mul_vld_r;
  pgc_item_t mul_item_r;
  logic [PW-1:0] prod_r;
  logic [PW-1:0] prod_nxt;

  assign prod_nxt = PW'(mod_rem) * PW'(size_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_vld_r <= 1'b0;
    end else begin
      mul_vld_r <= mod_vld;
    end
  end

  always_ff @(posedge clk) begin
    mul_item_r <= mod_item;
    prod_r     <= prod_nxt;
  end

  // --------------------------------------------------------------------------
  // position on the cycle: (m * size << FRAC_BITS) / range
  // upper part of the numerator already sits below the range
  // --------------------------------------------------------------------------
  logic          pos_vld;
  logic [QW-1:0] pos_quo;
  pgc_item_t     pos_item;

  pgc_div_pipe #(
    .STEPS (QW),
    .DW    (RANGE_W),
    .SBW   ($bits(pgc_item_t))
  ) u_pos_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (mul_vld_r),
    .rem_i   (prod_r[AW +: RANGE_W]),
    .bits_i  ({prod_r[AW-1:0], FRAC_BITS'(0)}),
    .divisor (range_eff),
    .side_i  (mul_item_r),
    .valid_o (pos_vld),
    .rem_o   (),
    .quo_o   (pos_quo),
    .side_o  (pos_item)
  );

  // --------------------------------------------------------------------------
  // entry indexes: integer part plus offset, wrapped; second entry follows
  // --------------------------------------------------------------------------
  logic [SW:0]    idx_sum;
  logic [SW:0]    idx_wrap;
  logic [SW-1:0]  idx_first;
  logic [SW-1:0]  idx_succ;
  logic [SW-1:0]  idx_second;

  always_comb begin
    idx_sum    = (SW+1)'(pos_quo[QW-1 -: AW]) + (SW+1)'(start_mod_r);
    idx_wrap   = idx_sum - {1'b0, size_eff};
    idx_first  = (idx_sum >= {1'b0, size_eff}) ? idx_wrap[SW-1:0] : idx_sum[SW-1:0];
    idx_succ   = idx_first + SW'(1);
    idx_second = (idx_succ == size_eff) ? '0 : idx_succ;
  end

  logic                 idx_vld_r;
  pgc_item_t            idx_item_r;
  logic [AW-1:0]        idx_i1_r;
  logic [AW-1:0]        idx_i2_r;
  logic [FRAC_BITS-1:0] idx_frac_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_vld_r <= 1'b0;
    end else begin
      idx_vld_r <= pos_vld;
    end
  end

  always_ff @(posedge clk) begin
    idx_item_r <= pos_item;
    idx_i1_r   <= AW'(idx_first);
    idx_i2_r   <= AW'(idx_second);
    idx_frac_r <= pos_quo[FRAC_BITS-1:0];
  end

  // --------------------------------------------------------------------------
  // palette memory: writes and reads issue in transaction order from the
  // same stage, so a read always sees earlier writes without forwarding
  // --------------------------------------------------------------------------
  pgc_wr_t            pal_wr;
  logic [COLOR_W-1:0] pal_a;
  logic [COLOR_W-1:0] pal_b;

  assign pal_wr.en   = idx_vld_r && (idx_item_r.operation == OP_WRITE);
  assign pal_wr.idx  = idx_item_r.entry_index;
  assign pal_wr.data = idx_item_r.entry_color;

  pgc_palette_mem #(
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk       (clk),
    .wr        (pal_wr),
    .rd_addr_a (idx_i1_r),
    .rd_addr_b (idx_i2_r),
    .rd_data_a (pal_a),
    .rd_data_b (pal_b)
  );

  // fraction and strobe follow the memory read latency
  logic                 rd_vld_r;
  logic [FRAC_BITS-1:0] rd_frac_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= idx_vld_r && (idx_item_r.operation == OP_COLOR);
    end
  end

  always_ff @(posedge clk) begin
    rd_frac_r <= idx_frac_r;
  end

  // --------------------------------------------------------------------------
  // channel blend and output register
  // --------------------------------------------------------------------------
  pgc_blend #(
    .FRAC_BITS (FRAC_BITS)
  ) u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_i   (rd_vld_r),
    .color_a_i (pal_a),
    .color_b_i (pal_b),
    .frac_i    (rd_frac_r),
    .valid_o   (out_valid),
    .color_o   (out_pixel_color)
  );

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  logic in_accept_color;

  assign in_accept_color = in_accept && (in_operation == OP_COLOR);

  // every color transaction produces its strobe after the fixed latency
  a_color_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept_color |-> ##LAT out_valid)
    else $error("color transaction produced no result");

  // no strobe without a color transaction taken the latency before
  a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_accept_color, LAT))
    else $error("result strobe without a color transaction");

  // entry indexes lie inside the cycle and the second follows the first
  a_index_in_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (idx_vld_r && (idx_item_r.operation == OP_COLOR)) |->
      ((SW'(idx_i1_r) < size_eff) &&
       ((SW'(idx_i2_r) == SW'(idx_i1_r) + SW'(1)) ||
        ((idx_i2_r == '0) && (SW'(idx_i1_r) + SW'(1) == size_eff)))))
    else $error("palette index outside the cycle");

endmodule
